### rtl/core/password_check_with_lockout_assert.svh
// Assertion macros for the port-level checker.
`ifndef PASSWORD_CHECK_WITH_LOCKOUT_ASSERT_SVH
`define PASSWORD_CHECK_WITH_LOCKOUT_ASSERT_SVH

// Same-cycle implication
`define PWC_CHECK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PWC_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pwc_pkg.sv
package pwc_pkg;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int LANES    = DATA_W / BYTE_W;
  localparam int STATUS_W = 2;
  localparam int SECS_W   = 15;
  localparam int FAIL_W   = 4;
  localparam int TICK_W   = 24;

  // Saturation limits and reset values
  localparam logic [FAIL_W-1:0] FAIL_MAX            = '1;
  localparam logic [TICK_W-1:0] TICK_MAX            = '1;
  localparam logic [SECS_W-1:0] SECS_MAX            = '1;
  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RESET    = 4'd5;
  localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RESET = 24'd30000;

  // Item functions
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ATTEMPT = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_WRONG    = 2'd1,
    STATUS_TOO_MANY = 2'd2,
    STATUS_QUERY    = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FAIL_LIMIT    = 1'b0,
    CFG_LOCKOUT_TICKS = 1'b1
  } cfg_reg_t;

  // Verdict handed from the control unit to the result pipeline
  typedef struct packed {
    logic              emit;
    status_t           status;
    logic [TICK_W-1:0] left;
  } verdict_t;

endpackage

### rtl/core/pwc_if.sv
// Input item channel
interface pwc_in_if;
  import pwc_pkg::*;

  logic                valid;
  logic                ready;
  func_t               func;
  logic [INDEX_W-1:0]  word_index;
  logic [DATA_W-1:0]   word_data;
  logic                last;

  modport source (output valid, func, word_index, word_data, last, input ready);
  modport sink   (input valid, func, word_index, word_data, last, output ready);
endinterface

// Result item channel
interface pwc_out_if;
  import pwc_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [SECS_W-1:0]   remaining_seconds;
  logic                auth_required;

  modport source (output valid, status, remaining_seconds, auth_required, input ready);
  modport sink   (input valid, status, remaining_seconds, auth_required, output ready);
endinterface

### rtl/core/pwc_lane.sv
// One byte lane of the attempt compare: flags any differing bit
module pwc_lane (
  input  logic [pwc_pkg::BYTE_W-1:0] stored_byte,
  input  logic [pwc_pkg::BYTE_W-1:0] attempt_byte,
  output logic                       differs
);
  import pwc_pkg::*;

  logic [BYTE_W-1:0] delta;

  // no early exit: every bit is folded in
  assign delta   = stored_byte ^ attempt_byte;
  assign differs = |delta;

endmodule

### rtl/core/pwc_ctrl.sv
// Merges the lane flags and keeps failure count, tick counter and config
module pwc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  pwc_pkg::func_t             func,
  input  logic                       last,
  input  logic [pwc_pkg::LANES-1:0]  lane_diff,
  input  logic                       cfg_we,
  input  pwc_pkg::cfg_reg_t          cfg_index,
  input  logic [pwc_pkg::TICK_W-1:0] cfg_data,
  output pwc_pkg::verdict_t          verdict
);
  import pwc_pkg::*;

  logic [FAIL_W-1:0] fail_limit;
  logic [TICK_W-1:0] lockout_ticks;
  logic [FAIL_W-1:0] failure_count, failure_count_next;
  logic [TICK_W-1:0] ticks, ticks_next;
  logic              mismatch_seen, mismatch_seen_next;

  logic              wrong;
  logic              limit_hit;
  logic              locked_now;
  logic              locked_next;
  logic [FAIL_W-1:0] fail_base;

  logic              v_emit;
  status_t           v_status;
  logic [TICK_W-1:0] v_left;

  // merge stage: any lane mismatch marks the attempt wrong
  assign wrong      = mismatch_seen | (|lane_diff);
  assign limit_hit  = failure_count >= fail_limit;
  assign locked_now = limit_hit && (ticks < lockout_ticks);
  // an elapsed lockout clears the count before the verdict
  assign fail_base  = limit_hit ? '0 : failure_count;

  // next state and verdict for the accepted item
  always_comb begin
    failure_count_next = failure_count;
    ticks_next         = ticks;
    mismatch_seen_next = mismatch_seen;
    v_emit             = 1'b0;
    v_status           = STATUS_QUERY;
    if (accept) begin
      unique case (func)
        FUNC_LOAD: begin
        end
        FUNC_ATTEMPT: begin
          if (!last) begin
            mismatch_seen_next = wrong;
          end else begin
            mismatch_seen_next = 1'b0;
            v_emit             = 1'b1;
            if (locked_now) begin
              v_status = STATUS_TOO_MANY;
            end else if (!wrong) begin
              failure_count_next = '0;
              v_status           = STATUS_OK;
            end else begin
              failure_count_next = (fail_base != FAIL_MAX) ? fail_base + 1'b1 : fail_base;
              ticks_next         = '0;
              v_status           = STATUS_WRONG;
            end
          end
        end
        FUNC_TICK: begin
          if (ticks != TICK_MAX) ticks_next = ticks + 1'b1;
        end
        FUNC_QUERY: begin
          v_emit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // lockout ticks left, taken after this item's update
  assign locked_next = (failure_count_next >= fail_limit) && (ticks_next < lockout_ticks);
  assign v_left      = locked_next ? lockout_ticks - ticks_next : '0;
  assign verdict     = '{emit: v_emit, status: v_status, left: v_left};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      failure_count <= '0;
      ticks         <= '0;
      mismatch_seen <= 1'b0;
    end else begin
      failure_count <= failure_count_next;
      ticks         <= ticks_next;
      mismatch_seen <= mismatch_seen_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit    <= FAIL_LIMIT_RESET;
      lockout_ticks <= LOCKOUT_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAIL_LIMIT:    fail_limit    <= cfg_data[FAIL_W-1:0];
        CFG_LOCKOUT_TICKS: lockout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/pwc_secs.sv
// Ticks left to whole seconds, rounded up, by reciprocal multiply
module pwc_secs #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic [pwc_pkg::TICK_W-1:0] left,
  output logic [pwc_pkg::SECS_W-1:0] seconds
);
  import pwc_pkg::*;

  // exact floor division for numerators below 2^NUM_W
  localparam int              NUM_W  = TICK_W + 1;
  localparam int              SHIFT  = NUM_W + $clog2(TICKS_PER_SECOND);
  localparam longint unsigned RECIP  = ((64'd1 << SHIFT) + TICKS_PER_SECOND - 1)
                                       / TICKS_PER_SECOND;
  localparam int              MUL_W  = NUM_W + 2;
  localparam int              PROD_W = NUM_W + MUL_W;

  logic [NUM_W-1:0]  num;
  logic [MUL_W-1:0]  recip;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  quot;

  assign recip = MUL_W'(RECIP);
  // round up: add divisor minus one first
  assign num   = {1'b0, left} + NUM_W'(TICKS_PER_SECOND - 1);
  assign prod  = {{MUL_W{1'b0}}, num} * {{NUM_W{1'b0}}, recip};
  assign quot  = NUM_W'(prod >> SHIFT);

  // saturate to the field
  assign seconds = (quot > NUM_W'(SECS_MAX)) ? SECS_MAX : SECS_W'(quot);

endmodule

### rtl/core/password_check_with_lockout.sv
// A result passes the verdict stage register, then the output register, once its item is accepted.
// One item per cycle while in_ch.ready is high; the byte compare runs in eight parallel lanes.
// The output register and the verdict stage let a new item in while a result waits.
// Reset (rst, synchronous): clears counters and pipeline; stored words read as zero;
// the failure limit returns to 5 and lockout_ticks to 30000.
module password_check_with_lockout #(
  parameter int PASSWORD_WORDS   = 8,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                       clk,
  input  logic                       rst,
  pwc_in_if.sink                     in_ch,
  pwc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  pwc_pkg::cfg_reg_t          cfg_index,
  input  logic [pwc_pkg::TICK_W-1:0] cfg_data
);
  import pwc_pkg::*;

  localparam int WADDR_W = (PASSWORD_WORDS > 1) ? $clog2(PASSWORD_WORDS) : 1;

  // password words and their written flags
  logic [DATA_W-1:0]         pw_word [PASSWORD_WORDS];
  logic [PASSWORD_WORDS-1:0] word_valid;

  logic               accept;
  logic               in_range;
  logic [WADDR_W-1:0] waddr;
  logic [DATA_W-1:0]  rd_word;
  logic [LANES-1:0]   lane_diff;
  logic               auth;
  verdict_t           verdict;

  // verdict stage
  logic              a_valid;
  status_t           a_status;
  logic [TICK_W-1:0] a_left;
  logic              a_auth;

  // output register
  logic              o_valid;
  status_t           o_status;
  logic [SECS_W-1:0] o_secs;
  logic              o_auth;
  logic [SECS_W-1:0] secs;

  logic adv_out;
  logic adv_a;

  // pipeline flow
  assign adv_out      = !o_valid || out_ch.ready;
  assign adv_a        = !a_valid || adv_out;
  assign in_ch.ready  = adv_a;
  assign accept       = in_ch.valid && adv_a;

  // word addressing; words past the store compare as zero padding
  assign in_range = {29'd0, in_ch.word_index} < 32'(PASSWORD_WORDS);
  assign waddr    = WADDR_W'(in_ch.word_index);
  assign rd_word  = (in_range && word_valid[waddr]) ? pw_word[waddr] : '0;
  assign auth     = word_valid[0] && (pw_word[0][BYTE_W-1:0] != '0);

  // password store writes
  always_ff @(posedge clk) begin
    if (accept && in_ch.func == FUNC_LOAD && in_range) begin
      pw_word[waddr] <= in_ch.word_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (accept && in_ch.func == FUNC_LOAD && in_range) begin
      word_valid[waddr] <= 1'b1;
    end
  end

  // byte compare lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pwc_lane u_lane (
      .stored_byte  (rd_word[l*BYTE_W +: BYTE_W]),
      .attempt_byte (in_ch.word_data[l*BYTE_W +: BYTE_W]),
      .differs      (lane_diff[l])
    );
  end

  // merge, counters and verdict
  pwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (in_ch.func),
    .last      (in_ch.last),
    .lane_diff (lane_diff),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .verdict   (verdict)
  );

  // verdict stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= accept && verdict.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_status <= verdict.status;
      a_left   <= verdict.left;
      a_auth   <= auth;
    end
  end

  // seconds conversion
  pwc_secs #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_secs (
    .left    (a_left),
    .seconds (secs)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv_out) begin
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      o_status <= a_status;
      o_secs   <= secs;
      o_auth   <= a_auth;
    end
  end

  assign out_ch.valid             = o_valid;
  assign out_ch.status            = o_status;
  assign out_ch.remaining_seconds = o_secs;
  assign out_ch.auth_required     = o_auth;

endmodule

### rtl/core/pwc_checker.sv
// Port-level checks for the password block
module pwc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input pwc_pkg::status_t           out_status,
  input logic [pwc_pkg::SECS_W-1:0] out_secs,
  input logic                       out_auth
);
  import pwc_pkg::*;

  `include "password_check_with_lockout_assert.svh"

  // no result right after reset
  `PWC_CHECK_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result valid after reset")

  // an empty output register never blocks the input
  `PWC_CHECK_IMPL(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled with empty output")

  // a refused attempt always has lockout time left
  `PWC_CHECK_IMPL(a_too_many_secs, clk, rst, out_valid && out_status == STATUS_TOO_MANY, out_secs != '0, "too_many with zero seconds")

  // a stalled result holds
  `PWC_CHECK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_secs) && $stable(out_auth), "stalled result changed")

endmodule

bind password_check_with_lockout pwc_checker u_pwc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_secs   (out_ch.remaining_seconds),
  .out_auth   (out_ch.auth_required)
);

### bench/pwc_lockout_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of password_check_with_lockout,
// tracks the lockout state on its own and compares every result item field by
// field with the oldest expected reply.
module pwc_lockout_checker #(
  parameter int PASSWORD_WORDS   = 8,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                       clk,
  input  logic                       rst,
  pwc_in_if                          in_ch,
  pwc_out_if                         out_ch,
  input  logic                       cfg_we,
  input  pwc_pkg::cfg_reg_t          cfg_index,
  input  logic [pwc_pkg::TICK_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);
  import pwc_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [SECS_W-1:0] seconds;
    logic              auth;
  } lockout_reply_t;

  // Tracked block state and register copies
  logic [DATA_W-1:0] stored_word [PASSWORD_WORDS];
  logic [FAIL_W-1:0] fail_cnt;
  logic [TICK_W-1:0] ticks_since;
  logic              diff_seen;
  logic [FAIL_W-1:0] max_fail;
  logic [TICK_W-1:0] lock_ticks;
  lockout_reply_t    replies_due [$];

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic bit locked_out();
    return fail_cnt >= max_fail && ticks_since < lock_ticks;
  endfunction

  // Lockout seconds left, rounded up and clipped to the field
  function automatic logic [SECS_W-1:0] seconds_left();
    int unsigned left;
    int unsigned secs;
    if (!locked_out()) return '0;
    left = lock_ticks - ticks_since;
    secs = (left + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
    if (secs > SECS_MAX) secs = SECS_MAX;
    return secs[SECS_W-1:0];
  endfunction

  function automatic void push_reply(status_t s);
    replies_due.push_back('{status: s, seconds: seconds_left(),
                            auth: stored_word[0][BYTE_W-1:0] != '0});
  endfunction

  // Advance the tracked state by one accepted item
  function automatic void apply_item(func_t f, logic [INDEX_W-1:0] idx,
                                     logic [DATA_W-1:0] data, logic last);
    logic [DATA_W-1:0] ref_word;
    logic              wrong;
    case (f)
      FUNC_LOAD: begin
        if (idx < PASSWORD_WORDS) stored_word[idx] = data;
      end
      FUNC_ATTEMPT: begin
        // words beyond the store compare against the zero padding
        ref_word = (idx < PASSWORD_WORDS) ? stored_word[idx] : '0;
        if (ref_word != data) diff_seen = 1'b1;
        if (last) begin
          wrong     = diff_seen;
          diff_seen = 1'b0;
          if (locked_out()) begin
            push_reply(STATUS_TOO_MANY);
          end else begin
            // an elapsed lockout forgets the old failures
            if (fail_cnt >= max_fail) fail_cnt = '0;
            if (!wrong) begin
              fail_cnt = '0;
              push_reply(STATUS_OK);
            end else begin
              if (fail_cnt != FAIL_MAX) fail_cnt++;
              ticks_since = '0;
              push_reply(STATUS_WRONG);
            end
          end
        end
      end
      FUNC_TICK: begin
        if (ticks_since != TICK_MAX) ticks_since++;
      end
      default: begin
        push_reply(STATUS_QUERY);
      end
    endcase
  endfunction

  // Results are checked before the item of the same edge is applied: a result
  // never belongs to an item accepted at the same edge.
  always @(posedge clk) begin : watch
    lockout_reply_t want;
    if (rst) begin
      foreach (stored_word[i]) stored_word[i] = '0;
      fail_cnt    = '0;
      ticks_since = '0;
      diff_seen   = 1'b0;
      max_fail    = FAIL_LIMIT_RESET;
      lock_ticks  = LOCKOUT_TICKS_RESET;
      replies_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          report($sformatf("result item with none due, status %0d", out_ch.status));
        end else begin
          want = replies_due.pop_front();
          if (out_ch.status !== want.status)
            report($sformatf("status expected %s, got %0d",
                             want.status.name(), out_ch.status));
          if (out_ch.remaining_seconds !== want.seconds)
            report($sformatf("remaining_seconds expected %0d, got %0d",
                             want.seconds, out_ch.remaining_seconds));
          if (out_ch.auth_required !== want.auth)
            report($sformatf("auth_required expected %0b, got %0b",
                             want.auth, out_ch.auth_required));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FAIL_LIMIT:    max_fail   = cfg_data[FAIL_W-1:0];
          CFG_LOCKOUT_TICKS: lock_ticks = cfg_data;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        apply_item(in_ch.func, in_ch.word_index, in_ch.word_data, in_ch.last);
    end
    pending = replies_due.size();
  end

endmodule

### bench/tb_password_check_with_lockout.sv
`timescale 1ns / 100ps

module tb_password_check_with_lockout;
  import pwc_pkg::*;

  localparam int PHASE_ITEMS  = 75;
  localparam int HOLD_CYCLES  = 150;
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [TICK_W-1:0] cfg_data;
  int                errors;
  int                pending;

  pwc_in_if  in_ch ();
  pwc_out_if out_ch ();

  password_check_with_lockout dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pwc_lockout_checker lockout_watch (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Stimulus-side copy of the loaded password, used to build attempts
  logic [DATA_W-1:0] pw_shadow [8];
  int                burst_left = 0;
  bit                hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_password_check_with_lockout: done, errors");
    $finish;
  end

  // Result side: ready follows one of four patterns, switched at random; on request it
  // holds off once for a long stretch so the block backs up into its input.
  initial begin : result_sink
    int mode;
    int left;
    bit phase_bit;
    bit held;
    mode      = 0;
    left      = 0;
    phase_bit = 1'b0;
    held      = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        phase_bit = ~phase_bit;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= phase_bit;
        endcase
      end
    end
  end

  // Offer one item, with bursts and random gaps; returns at the falling edge
  // after it was taken.
  task automatic send_item(func_t f, logic [INDEX_W-1:0] idx,
                           logic [DATA_W-1:0] data, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.word_index <= idx;
    in_ch.word_data  <= data;
    in_ch.last       <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_word(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
    send_item(FUNC_LOAD, idx, data, 1'($urandom_range(0, 1)));
    pw_shadow[idx] = data;
  endtask

  task automatic query();
    send_item(FUNC_QUERY, 3'($urandom_range(0, 7)), {$urandom, $urandom},
              1'($urandom_range(0, 1)));
  endtask

  task automatic tick_run(int n);
    repeat (n)
      send_item(FUNC_TICK, 3'($urandom_range(0, 7)), {$urandom, $urandom},
                1'($urandom_range(0, 1)));
  endtask

  // Any field combination at all
  task automatic noise_item();
    func_t             f;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  data;
    f    = func_t'($urandom_range(0, 3));
    idx  = 3'($urandom_range(0, 7));
    data = {$urandom, $urandom};
    send_item(f, idx, data, 1'($urandom_range(0, 1)));
    if (f == FUNC_LOAD) pw_shadow[idx] = data;
  endtask

  // New zero-padded password of random length; now and then byte 0 is zero
  // while later bytes are not.
  task automatic load_password();
    int                len;
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 9))
      0:          len = 0;
      1, 2, 3, 4: len = $urandom_range(1, 8);
      default:    len = $urandom_range(9, 64);
    endcase
    for (int k = 0; k < 8; k++) begin
      w = '0;
      for (int j = 0; j < 8; j++)
        if (k * 8 + j < len) w[j*8 +: 8] = 8'($urandom_range(1, 255));
      if (k == 0 && $urandom_range(0, 6) == 0) w[7:0] = 8'h00;
      put_word(3'(k), w);
    end
  endtask

  // Password attempt of n words, last flag on the final one; a wrong attempt
  // corrupts one word, an unordered one picks word indexes at random.
  task automatic attempt(int n, bit wrong, bit ordered);
    int                bad;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  d;
    bad = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      idx = ordered ? 3'(k) : 3'($urandom_range(0, 7));
      d   = pw_shadow[idx];
      if (wrong && k == bad) begin
        if ($urandom_range(0, 1) != 0) d ^= 64'd1 << $urandom_range(0, 63);
        else d ^= {$urandom, $urandom} | 64'd1;
      end
      send_item(FUNC_ATTEMPT, idx, d, k == n - 1);
    end
  endtask

  // Let every due result come out, then wait for items still in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int unsigned v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v[TICK_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One setting of the registers, then a random mix of well-formed attempts,
  // ticks, queries, password loads and noise.
  task automatic random_phase(int max_f, int lock, int wrong_pct,
                              int forced_wrongs, bit squeeze);
    int done;
    int act;
    int n;
    write_reg(CFG_FAIL_LIMIT, max_f);
    write_reg(CFG_LOCKOUT_TICKS, lock);
    done = 0;
    if (squeeze) begin
      hold_req = 1'b1;
      repeat (24) query();
      done += 24;
    end
    repeat (forced_wrongs) attempt(1, 1'b1, 1'b1);
    done += forced_wrongs;
    while (done < PHASE_ITEMS) begin
      act = $urandom_range(0, 99);
      if (act < 45) begin
        n = ($urandom_range(0, 1) != 0) ? 8 : $urandom_range(1, 3);
        attempt(n, $urandom_range(0, 99) < wrong_pct, $urandom_range(0, 4) != 0);
        done += n;
      end else if (act < 60) begin
        n = $urandom_range(1, 6);
        tick_run(n);
        done += n;
      end else if (act < 65) begin
        // long tick runs let short lockouts run out
        if (lock <= 64) begin
          n = $urandom_range(lock / 2, lock + 4);
          tick_run(n);
          done += n;
        end
      end else if (act < 80) begin
        query();
        done++;
      end else if (act < 88) begin
        load_password();
        done += 8;
      end else begin
        noise_item();
        done++;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_FAIL_LIMIT;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_LOAD;
    in_ch.word_index = '0;
    in_ch.word_data  = '0;
    in_ch.last       = 1'b0;
    foreach (pw_shadow[i]) pw_shadow[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: one failure locks, lockout of just over a second
    write_reg(CFG_FAIL_LIMIT, 1);
    write_reg(CFG_LOCKOUT_TICKS, 1001);
    query();
    // empty password: a single zero word matches
    send_item(FUNC_ATTEMPT, 3'd0, '0, 1'b1);
    put_word(3'd0, 64'h0000_0000_6463_6261);
    put_word(3'd7, '1);
    query();
    // wrong top bit: locks, rounding gives two seconds, then one
    send_item(FUNC_ATTEMPT, 3'd0, pw_shadow[0] ^ 64'h8000_0000_0000_0000, 1'b1);
    tick_run(1);
    query();
    // right password while locked is refused
    send_item(FUNC_ATTEMPT, 3'd0, pw_shadow[0], 1'b1);
    write_reg(CFG_LOCKOUT_TICKS, 2);
    tick_run(1);
    query();
    // lockout has run out: failures cleared, then a match
    send_item(FUNC_ATTEMPT, 3'd0, pw_shadow[0], 1'b0);
    send_item(FUNC_ATTEMPT, 3'd1, '0, 1'b1);
    // mismatch in an early word carries to the last one
    send_item(FUNC_ATTEMPT, 3'd3, 64'h1, 1'b0);
    send_item(FUNC_ATTEMPT, 3'd7, '1, 1'b1);
    // refused attempt drops its mismatch
    send_item(FUNC_ATTEMPT, 3'd1, 64'h5, 1'b0);
    send_item(FUNC_ATTEMPT, 3'd0, pw_shadow[0], 1'b1);
    query();
    tick_run(2);
    send_item(FUNC_ATTEMPT, 3'd0, pw_shadow[0], 1'b1);
    // byte 0 zero: no password required though other bytes are set
    put_word(3'd0, 64'hFFFF_FFFF_FFFF_FF00);
    query();

    // Random part over several register settings
    random_phase(5, 30000, 50, 0, 1'b0);
    random_phase(1, 0, 50, 0, 1'b1);
    random_phase(15, 16777215, 60, 16, 1'b0);
    random_phase(2, 5, 50, 0, 1'b0);
    random_phase(3, 1500, 50, 0, 1'b0);
    random_phase(0, 3, 50, 0, 1'b0);
    random_phase(4, 40, 50, 0, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_password_check_with_lockout: done, clean");
    end else begin
      $display("tb_password_check_with_lockout: done, errors");
    end
    $finish;
  end

endmodule
